@@ rtl/core/mtxy_pkg.sv @@
package mtxy_pkg;

	localparam int MAX_SIDE   = 16;
	// 8-bit ids and at most 31 hops cover a 16 x 16 grid at most
	localparam int SIDE_LIMIT = (MAX_SIDE < 16) ? MAX_SIDE : 16;

	localparam int SIDE_W    = 5;
	localparam int ID_W      = 8;
	localparam int COORD_W   = 4;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GRID_SIDE  = 2'd0,
		CFG_WRAPAROUND = 2'd1,
		CFG_SNAKE      = 2'd2
	} mtxy_cfg_idx_t;

	typedef struct packed {
		logic [SIDE_W-1:0] side;
		logic              wrap;
		logic              snake;
	} mtxy_cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SETUP,
		ST_DIVIDE,
		ST_PLACE,
		ST_EMIT,
		ST_ERROR
	} mtxy_state_t;

	typedef struct packed {
		logic capture;
		logic check;
		logic setup;
		logic step;
		logic place;
		logic load_hop;
		logic load_err;
	} mtxy_cmd_t;

	typedef struct packed {
		logic id_error;
		logic div_done;
		logic at_goal;
	} mtxy_sts_t;

endpackage

@@ rtl/core/mtxy_cfg.sv @@
module mtxy_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mtxy_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mtxy_pkg::SIDE_W-1:0]      cfg_data,
	output mtxy_pkg::mtxy_cfg_t              cfg
);
	import mtxy_pkg::*;

	logic [SIDE_W-1:0] side_q;
	logic              wrap_q;
	logic              snake_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q  <= SIDE_W'(4);
			wrap_q  <= 1'b0;
			snake_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GRID_SIDE:  side_q  <= cfg_data;
				CFG_WRAPAROUND: wrap_q  <= cfg_data[0];
				CFG_SNAKE:      snake_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg.side  = side_q;
	assign cfg.wrap  = wrap_q;
	assign cfg.snake = snake_q;

endmodule

@@ rtl/core/mtxy_ctrl.sv @@
module mtxy_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  mtxy_pkg::mtxy_sts_t  sts,
	output mtxy_pkg::mtxy_cmd_t  cmd
);
	import mtxy_pkg::*;

	mtxy_state_t state_q, state_d;
	logic        out_valid_q;
	logic        can_load;

	// output register is free, or its word leaves this cycle
	assign can_load = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_CHECK;
			ST_CHECK:  state_d = sts.id_error ? ST_ERROR : ST_SETUP;
			ST_SETUP:  state_d = ST_DIVIDE;
			ST_DIVIDE: if (sts.div_done) state_d = ST_PLACE;
			ST_PLACE:  state_d = ST_EMIT;
			ST_EMIT:   if (can_load && sts.at_goal) state_d = ST_IDLE;
			ST_ERROR:  if (can_load) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_CHECK:  cmd.check = 1'b1;
			ST_SETUP:  cmd.setup = 1'b1;
			ST_DIVIDE: cmd.step  = 1'b1;
			ST_PLACE:  cmd.place = 1'b1;
			ST_EMIT:   cmd.load_hop = can_load;
			ST_ERROR:  cmd.load_err = can_load;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_hop || cmd.load_err) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.load_hop, cmd.load_err}))
		else $error("more than one load command at once");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !(cmd.load_hop || cmd.load_err))
		else $error("pending output word overwritten");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_hop && sts.at_goal) |=> (state_q == ST_IDLE))
		else $error("route did not end after last hop");

endmodule

@@ rtl/core/mtxy_dpath.sv @@
module mtxy_dpath (
	input  logic                          clk,
	input  mtxy_pkg::mtxy_cfg_t           cfg,
	input  logic [mtxy_pkg::ID_W-1:0]     source_node,
	input  logic [mtxy_pkg::ID_W-1:0]     target_node,
	input  mtxy_pkg::mtxy_cmd_t           cmd,
	output mtxy_pkg::mtxy_sts_t           sts,
	output logic [mtxy_pkg::ID_W-1:0]     hop_node,
	output logic                          last_hop,
	output logic                          route_error
);
	import mtxy_pkg::*;

	// how a logical id is placed on the grid
	typedef enum logic [1:0] {
		K_PLAIN,   // row-major, divide by side
		K_TOP,     // snake row 0
		K_MID,     // snake serpentine rows, divide by side-1
		K_LEFT     // snake return path up column 0
	} mtxy_kind_t;

	typedef struct packed {
		mtxy_kind_t      kind;
		logic [ID_W-1:0] rem;
	} mtxy_seed_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} mtxy_xy_t;

	logic [ID_W-1:0]    src_q, dst_q;
	logic [ID_W-1:0]    inner_q;
	logic [SIDE_W-1:0]  div_q;
	mtxy_kind_t         skind_q, dkind_q;
	logic [ID_W-1:0]    srem_q, drem_q;
	logic [COORD_W-1:0] squo_q, dquo_q;
	logic [COORD_W-1:0] cursor_x_q, cursor_y_q, goal_x_q, goal_y_q;
	logic               tie_q;
	logic [ID_W-1:0]    hop_q;
	logic               last_q, err_q;

	logic [2*SIDE_W-1:0] side_sq;
	logic [2*SIDE_W-1:0] inner_full;
	logic                s_done, d_done;
	mtxy_seed_t          s_seed, d_seed;
	mtxy_xy_t            s_xy, d_xy;
	logic [COORD_W-1:0]  nx_x, nx_y;
	logic [ID_W-1:0]     hop_d;

	function automatic mtxy_seed_t seed_id(input logic [ID_W-1:0] idx,
			input mtxy_cfg_t c, input logic [ID_W-1:0] inner);
		logic [ID_W:0] lim;
		mtxy_seed_t    r;
		lim = {1'b0, inner} + (ID_W+1)'(c.side);
		if (!c.snake) begin
			r.kind = K_PLAIN;
			r.rem  = idx;
		end else if ({1'b0, idx} < (ID_W+1)'(c.side)) begin
			r.kind = K_TOP;
			r.rem  = idx;
		end else if ({1'b0, idx} < lim) begin
			r.kind = K_MID;
			r.rem  = idx - ID_W'(c.side);
		end else begin
			r.kind = K_LEFT;
			r.rem  = ID_W'({1'b0, idx} - lim);
		end
		return r;
	endfunction

	function automatic mtxy_xy_t place_id(input mtxy_kind_t kind,
			input logic [ID_W-1:0] rem, input logic [COORD_W-1:0] quo,
			input logic [SIDE_W-1:0] side);
		logic [COORD_W-1:0] row;
		mtxy_xy_t           r;
		row = quo + COORD_W'(1);
		case (kind)
			K_PLAIN: begin
				r.x = rem[COORD_W-1:0];
				r.y = quo;
			end
			K_TOP: begin
				r.x = rem[COORD_W-1:0];
				r.y = '0;
			end
			K_MID: begin
				r.y = row;
				// odd rows run right to left
				r.x = row[0] ? COORD_W'(side - SIDE_W'(1) - rem[SIDE_W-1:0])
				             : rem[COORD_W-1:0] + COORD_W'(1);
			end
			K_LEFT: begin
				r.x = '0;
				r.y = COORD_W'(side - SIDE_W'(1) - rem[SIDE_W-1:0]);
			end
			default: begin
				r.x = '0;
				r.y = '0;
			end
		endcase
		return r;
	endfunction

	// one hop along a ring or a line of n nodes
	function automatic logic [COORD_W-1:0] step_to(input logic [COORD_W-1:0] cur,
			input logic [COORD_W-1:0] tgt, input logic [SIDE_W-1:0] n,
			input logic wrap, input logic back);
		logic [SIDE_W-1:0]  diff, fwd, bwd;
		logic [COORD_W-1:0] inc, dec, r;
		diff = SIDE_W'(tgt) + n - SIDE_W'(cur);
		fwd  = (diff >= n) ? diff - n : diff;
		bwd  = n - fwd;
		inc  = ((SIDE_W'(cur) + SIDE_W'(1)) == n) ? '0 : cur + COORD_W'(1);
		dec  = (cur == '0) ? COORD_W'(n - SIDE_W'(1)) : cur - COORD_W'(1);
		if (!wrap) begin
			r = (tgt > cur) ? inc : dec;
		end else if (fwd < bwd) begin
			r = inc;
		end else if (bwd < fwd) begin
			r = dec;
		end else begin
			r = back ? dec : inc;
		end
		return r;
	endfunction

	assign side_sq    = {{SIDE_W{1'b0}}, cfg.side} * {{SIDE_W{1'b0}}, cfg.side};
	assign inner_full = {{SIDE_W{1'b0}}, cfg.side - SIDE_W'(1)}
	                  * {{SIDE_W{1'b0}}, cfg.side - SIDE_W'(1)};

	assign sts.id_error = (cfg.side == '0) || (cfg.side > SIDE_W'(SIDE_LIMIT))
		|| ((2*SIDE_W)'(src_q) >= side_sq) || ((2*SIDE_W)'(dst_q) >= side_sq)
		|| (cfg.snake && cfg.side[0]);

	assign s_seed = seed_id(src_q, cfg, inner_q);
	assign d_seed = seed_id(dst_q, cfg, inner_q);

	assign s_done = !(skind_q == K_PLAIN || skind_q == K_MID) || (srem_q < ID_W'(div_q));
	assign d_done = !(dkind_q == K_PLAIN || dkind_q == K_MID) || (drem_q < ID_W'(div_q));
	assign sts.div_done = s_done && d_done;

	assign s_xy = place_id(skind_q, srem_q, squo_q, cfg.side);
	assign d_xy = place_id(dkind_q, drem_q, dquo_q, cfg.side);

	assign sts.at_goal = (cursor_x_q == goal_x_q) && (cursor_y_q == goal_y_q);

	// X first, then Y
	always_comb begin
		nx_x = cursor_x_q;
		nx_y = cursor_y_q;
		if (cursor_x_q != goal_x_q) begin
			nx_x = step_to(cursor_x_q, goal_x_q, cfg.side, cfg.wrap, tie_q);
		end else if (cursor_y_q != goal_y_q) begin
			nx_y = step_to(cursor_y_q, goal_y_q, cfg.side, cfg.wrap, tie_q);
		end
	end

	assign hop_d = ID_W'(ID_W'(cursor_y_q) * ID_W'(cfg.side)) + ID_W'(cursor_x_q);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			src_q <= source_node;
			dst_q <= target_node;
		end
		if (cmd.check) begin
			inner_q <= inner_full[ID_W-1:0];
		end
		if (cmd.setup) begin
			div_q   <= cfg.snake ? cfg.side - SIDE_W'(1) : cfg.side;
			skind_q <= s_seed.kind;
			srem_q  <= s_seed.rem;
			squo_q  <= '0;
			dkind_q <= d_seed.kind;
			drem_q  <= d_seed.rem;
			dquo_q  <= '0;
		end
		if (cmd.step) begin
			if (!s_done) begin
				srem_q <= srem_q - ID_W'(div_q);
				squo_q <= squo_q + COORD_W'(1);
			end
			if (!d_done) begin
				drem_q <= drem_q - ID_W'(div_q);
				dquo_q <= dquo_q + COORD_W'(1);
			end
		end
		if (cmd.place) begin
			cursor_x_q <= s_xy.x;
			cursor_y_q <= s_xy.y;
			goal_x_q   <= d_xy.x;
			goal_y_q   <= d_xy.y;
			// parity of the physical source id y*side+x
			tie_q      <= (s_xy.y[0] & cfg.side[0]) ^ s_xy.x[0];
		end
		if (cmd.load_hop) begin
			hop_q      <= hop_d;
			last_q     <= sts.at_goal;
			err_q      <= 1'b0;
			cursor_x_q <= nx_x;
			cursor_y_q <= nx_y;
		end
		if (cmd.load_err) begin
			hop_q  <= '0;
			last_q <= 1'b1;
			err_q  <= 1'b1;
		end
	end

	assign hop_node    = hop_q;
	assign last_hop    = last_q;
	assign route_error = err_q;

endmodule

@@ rtl/core/mesh_torus_xy_route_generator.sv @@
// Sequence: an accepted request is captured, checked and set up; both ids are then divided
//   by repeated subtract-and-count (quotient 0..15: row index, or row less one on a snake
//   serpentine row), placed on the grid and emitted; an error word follows the check.
// Throughput: one hop word per cycle while out_ready holds; a route of h hops (h <= 31)
//   holds the block until its last hop, and the next request is taken the cycle after it.
// Reset: arst_n clears the controller and output valid; grid_side resets to 4, others to 0.
module mesh_torus_xy_route_generator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mtxy_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mtxy_pkg::SIDE_W-1:0]       cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [mtxy_pkg::ID_W-1:0]         source_node,
	input  logic [mtxy_pkg::ID_W-1:0]         target_node,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [mtxy_pkg::ID_W-1:0]         hop_node,
	output logic                              last_hop,
	output logic                              route_error
);
	import mtxy_pkg::*;

	mtxy_cfg_t cfg;
	mtxy_cmd_t cmd;
	mtxy_sts_t sts;

	mtxy_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mtxy_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mtxy_dpath u_dpath (
		.clk         (clk),
		.cfg         (cfg),
		.source_node (source_node),
		.target_node (target_node),
		.cmd         (cmd),
		.sts         (sts),
		.hop_node    (hop_node),
		.last_hop    (last_hop),
		.route_error (route_error)
	);

endmodule
